FILE: rtl/sq_cipher_pkg.sv
// Shared constants and types for the square transposition cipher.
package sq_cipher_pkg;

  localparam int MAX_CHARS = 32;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  // Side never exceeds ceil(sqrt(32)) = 6 over the supported capacity range.
  localparam int MAX_SIDE  = 8;
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int IDX_W     = 2 * SIDE_W;
  localparam int TOT_W     = $clog2(MAX_SIDE * MAX_SIDE + MAX_SIDE);
  localparam int COLS_W    = 3;
  localparam int OUT_W     = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIDE,
    S_ROWS,
    S_TOTAL,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/square_transposition_cipher.sv
// Square transposition cipher: filter, store, then read out column by column.
//
// Input stream (s_axis_*): one message byte per request; tuser flags a real
// byte, tlast ends the message. tready is high only while the block is
// collecting, so bytes load one per cycle. The end item starts encoding:
// the side c is found by stepping a shared small multiplier, then the row
// count r, then the output length. Emission then walks the column-major
// grid, one grid position or one separator per cycle while the output is
// not stalled. The input stays blocked from the end item until the walk is
// done, output stalls included.
// Output stream (m_axis_*): one ciphertext character per request held in an
// output register; a stall on m_axis_tready freezes the walk. tlast marks
// the last character. An empty message produces nothing.
// Config (cfg_*): output_mode, 0 padded space-separated columns, 1 plain;
// always ready; to be written only while idle (not enforced by the block).
// Reset (rst, synchronous): clears count, overflow flag, mode, output valid.
// The character store holds no reset value; only written entries are read.
module square_transposition_cipher (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] in_char
  input  logic                               s_axis_tuser,  // [0] char_valid
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] out_char, [10:8] column_total, [11] overflow, [15:12] zero
  output logic [sq_cipher_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);

  sq_cipher_pkg::state_t state, state_next;

  logic [6:0]                        store [sq_cipher_pkg::MAX_CHARS];
  logic [sq_cipher_pkg::CNT_W-1:0]   count;
  logic                              ovf;
  logic                              mode;
  logic [sq_cipher_pkg::SIDE_W-1:0]  side;
  logic [sq_cipher_pkg::SIDE_W-1:0]  rows;
  logic [sq_cipher_pkg::SIDE_W-1:0]  col;
  logic [sq_cipher_pkg::SIDE_W-1:0]  row;
  logic                              sep;
  logic [sq_cipher_pkg::TOT_W-1:0]   total;
  logic [sq_cipher_pkg::TOT_W-1:0]   k;

  logic [sq_cipher_pkg::SIDE_W-1:0]  mul_a, mul_b;
  logic [sq_cipher_pkg::IDX_W-1:0]   mul_p;
  logic [sq_cipher_pkg::IDX_W-1:0]   idx;
  logic                              below_n;
  logic                              in_acc;
  logic                              is_upper, keep, room, do_store;
  logic [7:0]                        lc_char;
  logic                              slot_free;
  logic                              hit, emit, last_row, last_col, done;
  logic                              from_store;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == sq_cipher_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // character filter and case fold
  always_comb begin
    is_upper = (s_axis_tdata >= sq_cipher_pkg::CH_UP_A) &&
               (s_axis_tdata <= sq_cipher_pkg::CH_UP_Z);
    keep     = is_upper ||
               ((s_axis_tdata >= sq_cipher_pkg::CH_LO_A) &&
                (s_axis_tdata <= sq_cipher_pkg::CH_LO_Z)) ||
               ((s_axis_tdata >= sq_cipher_pkg::CH_D0) &&
                (s_axis_tdata <= sq_cipher_pkg::CH_D9));
    lc_char  = is_upper ? (s_axis_tdata + sq_cipher_pkg::CASE_OFS) : s_axis_tdata;
    room     = (count < sq_cipher_pkg::CNT_W'(sq_cipher_pkg::MAX_CHARS));
    do_store = in_acc && s_axis_tuser && keep && room;
  end

  // shared multiplier
  always_comb begin
    unique case (state)
      sq_cipher_pkg::S_SIDE: begin
        mul_a = side;
        mul_b = side;
      end
      sq_cipher_pkg::S_EMIT: begin
        mul_a = row;
        mul_b = side;
      end
      default: begin
        mul_a = rows;
        mul_b = side;
      end
    endcase
    mul_p   = sq_cipher_pkg::IDX_W'(mul_a) * sq_cipher_pkg::IDX_W'(mul_b);
    below_n = (mul_p < sq_cipher_pkg::IDX_W'(count));
    idx     = mul_p + sq_cipher_pkg::IDX_W'(col);
  end

  // emission step
  always_comb begin
    slot_free  = !m_axis_tvalid || m_axis_tready;
    hit        = (idx < sq_cipher_pkg::IDX_W'(count));
    emit       = sep || hit || !mode;
    last_row   = (row == rows - sq_cipher_pkg::SIDE_W'(1));
    last_col   = (col == side - sq_cipher_pkg::SIDE_W'(1));
    from_store = !sep && hit;
    done       = (state == sq_cipher_pkg::S_EMIT) && slot_free && !sep &&
                 last_row && last_col;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sq_cipher_pkg::S_IDLE: begin
        if (in_acc && s_axis_tlast && ((count != '0) || do_store)) begin
          state_next = sq_cipher_pkg::S_SIDE;
        end
      end
      sq_cipher_pkg::S_SIDE: begin
        if (!below_n) begin
          state_next = sq_cipher_pkg::S_ROWS;
        end
      end
      sq_cipher_pkg::S_ROWS: begin
        if (!below_n) begin
          state_next = sq_cipher_pkg::S_TOTAL;
        end
      end
      sq_cipher_pkg::S_TOTAL: state_next = sq_cipher_pkg::S_EMIT;
      sq_cipher_pkg::S_EMIT: begin
        if (done) begin
          state_next = sq_cipher_pkg::S_IDLE;
        end
      end
      default: state_next = sq_cipher_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sq_cipher_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      store[count[sq_cipher_pkg::ADDR_W-1:0]] <= lc_char[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      ovf           <= 1'b0;
      mode          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      if ((state == sq_cipher_pkg::S_EMIT) && slot_free) begin
        m_axis_tvalid <= emit;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        sq_cipher_pkg::S_IDLE: begin
          if (do_store) begin
            count <= count + sq_cipher_pkg::CNT_W'(1);
          end else if (in_acc && s_axis_tuser && keep) begin
            ovf <= 1'b1;
          end
          if (in_acc && s_axis_tlast) begin
            side <= sq_cipher_pkg::SIDE_W'(1);
            if ((count == '0) && !do_store) begin
              ovf <= 1'b0;
            end
          end
        end
        sq_cipher_pkg::S_SIDE: begin
          if (below_n) begin
            side <= side + sq_cipher_pkg::SIDE_W'(1);
          end else begin
            rows <= sq_cipher_pkg::SIDE_W'(1);
          end
        end
        sq_cipher_pkg::S_ROWS: begin
          if (below_n) begin
            rows <= rows + sq_cipher_pkg::SIDE_W'(1);
          end
        end
        sq_cipher_pkg::S_TOTAL: begin
          total <= mode ? sq_cipher_pkg::TOT_W'(count)
                        : sq_cipher_pkg::TOT_W'(mul_p + sq_cipher_pkg::IDX_W'(side)
                                                - sq_cipher_pkg::IDX_W'(1));
          col   <= '0;
          row   <= '0;
          k     <= '0;
          sep   <= 1'b0;
        end
        sq_cipher_pkg::S_EMIT: begin
          if (slot_free) begin
            if (emit) begin
              m_axis_tdata  <= {{(sq_cipher_pkg::OUT_W - 12){1'b0}}, ovf,
                                side[sq_cipher_pkg::COLS_W-1:0],
                                from_store ? {1'b0, store[idx[sq_cipher_pkg::ADDR_W-1:0]]}
                                           : sq_cipher_pkg::CH_SPACE};
              m_axis_tlast  <= !sep && ((k + sq_cipher_pkg::TOT_W'(1)) == total);
              k             <= k + sq_cipher_pkg::TOT_W'(1);
            end
            if (sep) begin
              sep <= 1'b0;
              col <= col + sq_cipher_pkg::SIDE_W'(1);
              row <= '0;
            end else if (!last_row) begin
              row <= row + sq_cipher_pkg::SIDE_W'(1);
            end else if (!last_col) begin
              if (!mode) begin
                sep <= 1'b1;
              end else begin
                col <= col + sq_cipher_pkg::SIDE_W'(1);
                row <= '0;
              end
            end else begin
              count <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= sq_cipher_pkg::CNT_W'(sq_cipher_pkg::MAX_CHARS))
    else $error("stored count above capacity");

  a_side_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == sq_cipher_pkg::S_SIDE) |-> (count != '0))
    else $error("encoding started on an empty message");

  a_emit_geom: assert property (@(posedge clk) disable iff (rst)
    (state == sq_cipher_pkg::S_EMIT) |-> ((side != '0) && (rows != '0) &&
                                          (row < rows) && (col < side)))
    else $error("walk position outside the grid");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == sq_cipher_pkg::S_EMIT) |-> (k <= total))
    else $error("more characters emitted than the output length");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == sq_cipher_pkg::S_IDLE) && (count == '0) && !ovf)
    else $error("message state not cleared after emission");
`endif

endmodule
